// ===== sv/wfr_pkg.sv =====
`default_nettype none

package wfr_pkg;

    localparam int FRAMES_DEF          = 16;
    localparam int PAGE_BYTES          = 4096;
    localparam int PAGE_HEADER_BYTES   = 32;
    localparam int PAGE_DATA_BYTES     = PAGE_BYTES - PAGE_HEADER_BYTES;
    localparam int RECORD_HEADER_BYTES = 32;
    localparam int MAX_RECORD_BYTES    = 4064;
    localparam int RING_BUDGET_RST     = 61440;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TAKE   = 2'd1,
        OP_MARK   = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TOO_LARGE = 2'd1,
        STAT_RING_FULL = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

`default_nettype wire

// ===== sv/wfr_end_table.sv =====
`default_nettype none

module wfr_end_table
    import wfr_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    localparam int IW = $clog2(FRAMES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [63:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [IW-1:0] i_raddr,
    output logic [63:0]        o_rdata,
    output logic               o_busy
);

    logic [63:0]   r_mem [FRAMES];
    logic [63:0]   r_rdata;
    logic          r_busy;
    logic [IW-1:0] r_clr_idx;

    // zeroing sweep after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            if (r_clr_idx == IW'(FRAMES - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

// ===== sv/wal_frame_ring_lsn_allocator_top.sv =====
// Accept cycle latches operands and reads the frame end-LSN table; execute cycle updates
// state and registers the result word. o_ready is low during the execute cycle, so a new
// word is taken only after the table read-modify-write completes; while a result
// word waits on i_ready the execute cycle holds and o_ready stays low.
// Reset (synchronous, active low) clears the architectural state and o_valid; the end-LSN
// table is then zeroed, during which o_ready stays low. Config writes are taken at any time.
`default_nettype none

module wal_frame_ring_lsn_allocator_top
    import wfr_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [15:0] i_body_length,
    input  wire logic [4:0]  i_take_limit,
    input  wire logic [63:0] i_target_lsn,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [63:0]      o_record_lsn,
    output logic [3:0]       o_frame_index,
    output logic [11:0]      o_frame_offset,
    output logic             o_frame_closed,
    output logic [11:0]      o_closed_frame_used,
    output logic [63:0]      o_closed_frame_first_lsn,
    output logic [4:0]       o_frames_taken,
    output logic [3:0]       o_cursor_frame,
    output logic [63:0]      o_cursor_lsn,
    output logic [63:0]      o_flushed_lsn,
    output logic             o_reached
);

    localparam int IW = $clog2(FRAMES);
    localparam int NW = IW + 5;

    function automatic logic [3:0] low4(input logic [IW-1:0] v);
        logic [IW+3:0] x;
        x = {4'b0, v};
        return x[3:0];
    endfunction

    // architectural state
    t_state        r_state,       n_state;
    logic [16:0]   r_ring_budget;
    logic [63:0]   r_next_lsn,    n_next_lsn;
    logic [63:0]   r_flush_mark,  n_flush_mark;
    logic [IW-1:0] r_wr_frame,    n_wr_frame;
    logic [11:0]   r_wr_fill,     n_wr_fill;
    logic [63:0]   r_open_first,  n_open_first;
    logic [63:0]   r_open_last,   n_open_last;
    logic [IW-1:0] r_rd_frame,    n_rd_frame;

    // operands latched at accept
    t_op           r_op;
    logic [16:0]   r_total;
    logic          r_too_large;
    logic [63:0]   r_unfl;
    logic [63:0]   r_tgt;
    logic          r_tgt_gt;
    logic [4:0]    r_take_n;
    logic [IW-1:0] r_rd_next;

    // result word
    logic          r_o_valid,   n_o_valid;
    t_status       r_o_status,  n_o_status;
    logic [63:0]   r_o_rec_lsn, n_o_rec_lsn;
    logic [3:0]    r_o_fidx,    n_o_fidx;
    logic [11:0]   r_o_foff,    n_o_foff;
    logic          r_o_closed,  n_o_closed;
    logic [11:0]   r_o_used,    n_o_used;
    logic [63:0]   r_o_first,   n_o_first;
    logic [4:0]    r_o_taken,   n_o_taken;
    logic [3:0]    r_o_cfr,     n_o_cfr;
    logic [63:0]   r_o_clsn,    n_o_clsn;
    logic [63:0]   r_o_flsn,    n_o_flsn;
    logic          r_o_reached, n_o_reached;

    // table port
    logic          tbl_we;
    logic [IW-1:0] tbl_waddr;
    logic [63:0]   tbl_wdata;
    logic          tbl_re;
    logic [IW-1:0] tbl_raddr;
    logic [63:0]   tbl_rdata;
    logic          tbl_busy;

    // accept-cycle precompute
    logic          accept;
    logic [16:0]   a_total;
    logic [64:0]   a_diff;
    logic [IW:0]   a_w_x, a_r_x, a_avail;
    logic [NW-1:0] a_avail_n, a_lim_n, a_n, a_rx_n, a_last_s, a_next_s;
    logic [NW-1:0] a_last, a_rnext;

    // execute-cycle terms
    logic          out_free;
    logic [16:0]   room;
    logic          full;
    logic          need_close;
    logic [IW-1:0] wr_frame_inc, eff_frame;
    logic [11:0]   eff_fill;

    assign accept = i_valid && o_ready;

    always_comb begin
        a_total   = 17'(RECORD_HEADER_BYTES) + {1'b0, i_body_length};
        a_diff    = {1'b0, r_next_lsn} - {1'b0, r_flush_mark};
        a_w_x     = {1'b0, r_wr_frame};
        a_r_x     = {1'b0, r_rd_frame};
        if (a_w_x >= a_r_x) begin
            a_avail = a_w_x - a_r_x;
        end else begin
            a_avail = a_w_x + (IW+1)'(FRAMES) - a_r_x;
        end
        a_avail_n = NW'(a_avail);
        a_lim_n   = NW'(i_take_limit);
        a_n       = (a_avail_n < a_lim_n) ? a_avail_n : a_lim_n;
        a_rx_n    = NW'(r_rd_frame);
        // sums stay below 2*FRAMES, so one conditional subtract wraps them
        a_last_s  = a_rx_n + a_n - 1'b1;
        a_next_s  = a_rx_n + a_n;
        a_last    = (a_last_s >= NW'(FRAMES)) ? a_last_s - NW'(FRAMES) : a_last_s;
        a_rnext   = (a_next_s >= NW'(FRAMES)) ? a_next_s - NW'(FRAMES) : a_next_s;
    end

    assign tbl_re    = accept;
    assign tbl_raddr = a_last[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= t_op'(i_operation);
            r_total     <= a_total;
            r_too_large <= a_total > 17'(MAX_RECORD_BYTES);
            r_unfl      <= a_diff[64] ? 64'd0 : a_diff[63:0];
            r_tgt       <= i_target_lsn;
            r_tgt_gt    <= i_target_lsn > r_flush_mark;
            r_take_n    <= a_n[4:0];
            r_rd_next   <= a_rnext[IW-1:0];
        end
    end

    always_comb begin
        out_free     = !r_o_valid || i_ready;
        room         = r_ring_budget - r_total;
        full         = (r_total > r_ring_budget) || (|r_unfl[63:17])
                       || (r_unfl[16:0] > room);
        need_close   = (18'(r_wr_fill) + 18'(r_total)) > 18'(PAGE_DATA_BYTES);
        wr_frame_inc = (r_wr_frame == IW'(FRAMES - 1)) ? '0 : r_wr_frame + 1'b1;
        eff_frame    = need_close ? wr_frame_inc : r_wr_frame;
        eff_fill     = need_close ? 12'd0 : r_wr_fill;

        n_state      = r_state;
        n_next_lsn   = r_next_lsn;
        n_flush_mark = r_flush_mark;
        n_wr_frame   = r_wr_frame;
        n_wr_fill    = r_wr_fill;
        n_open_first = r_open_first;
        n_open_last  = r_open_last;
        n_rd_frame   = r_rd_frame;

        n_o_valid    = r_o_valid && !i_ready;
        n_o_status   = r_o_status;
        n_o_rec_lsn  = r_o_rec_lsn;
        n_o_fidx     = r_o_fidx;
        n_o_foff     = r_o_foff;
        n_o_closed   = r_o_closed;
        n_o_used     = r_o_used;
        n_o_first    = r_o_first;
        n_o_taken    = r_o_taken;
        n_o_cfr      = r_o_cfr;
        n_o_clsn     = r_o_clsn;
        n_o_flsn     = r_o_flsn;
        n_o_reached  = r_o_reached;

        tbl_we       = 1'b0;
        tbl_waddr    = r_wr_frame;
        tbl_wdata    = r_open_last;

        o_ready      = (r_state == S_IDLE) && !tbl_busy;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_o_valid   = 1'b1;
                    n_o_status  = STAT_OK;
                    n_o_rec_lsn = '0;
                    n_o_fidx    = '0;
                    n_o_foff    = '0;
                    n_o_closed  = 1'b0;
                    n_o_used    = '0;
                    n_o_first   = '0;
                    n_o_taken   = '0;
                    n_o_cfr     = '0;
                    n_o_clsn    = '0;
                    n_o_flsn    = r_flush_mark;
                    n_o_reached = 1'b0;
                    case (r_op)
                        OP_APPEND: begin
                            if (r_too_large) begin
                                n_o_status = STAT_TOO_LARGE;
                            end else if (full) begin
                                n_o_status = STAT_RING_FULL;
                            end else begin
                                // an empty frame is skipped without closing it
                                if (need_close && (r_wr_fill != 12'd0)) begin
                                    tbl_we     = 1'b1;
                                    n_o_closed = 1'b1;
                                    n_o_used   = r_wr_fill;
                                    n_o_first  = r_open_first;
                                end
                                n_o_rec_lsn = r_next_lsn;
                                n_o_fidx    = low4(eff_frame);
                                n_o_foff    = 12'(PAGE_HEADER_BYTES) + eff_fill;
                                if (eff_fill == 12'd0) begin
                                    n_open_first = r_next_lsn;
                                end
                                n_open_last = r_next_lsn;
                                n_wr_frame  = eff_frame;
                                n_wr_fill   = eff_fill + r_total[11:0];
                                n_next_lsn  = r_next_lsn + 64'(r_total);
                            end
                        end
                        OP_TAKE: begin
                            n_o_taken  = r_take_n;
                            n_o_cfr    = low4(r_rd_next);
                            n_o_clsn   = (r_take_n != 5'd0) ? tbl_rdata : 64'd0;
                            n_rd_frame = r_rd_next;
                        end
                        OP_MARK: begin
                            // flushed mark only rises
                            if (r_tgt_gt) begin
                                n_flush_mark = r_tgt;
                                n_o_flsn     = r_tgt;
                            end
                            n_o_reached = 1'b1;
                        end
                        OP_QUERY: begin
                            n_o_reached = !r_tgt_gt;
                        end
                        default: begin
                            n_o_reached = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ring_budget <= 17'(RING_BUDGET_RST);
            r_next_lsn    <= '0;
            r_flush_mark  <= '0;
            r_wr_frame    <= '0;
            r_wr_fill     <= '0;
            r_open_first  <= '0;
            r_open_last   <= '0;
            r_rd_frame    <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            if (i_cfg_we) begin
                r_ring_budget <= i_cfg_wdata;
            end
            r_next_lsn    <= n_next_lsn;
            r_flush_mark  <= n_flush_mark;
            r_wr_frame    <= n_wr_frame;
            r_wr_fill     <= n_wr_fill;
            r_open_first  <= n_open_first;
            r_open_last   <= n_open_last;
            r_rd_frame    <= n_rd_frame;
            r_o_valid     <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_status  <= n_o_status;
        r_o_rec_lsn <= n_o_rec_lsn;
        r_o_fidx    <= n_o_fidx;
        r_o_foff    <= n_o_foff;
        r_o_closed  <= n_o_closed;
        r_o_used    <= n_o_used;
        r_o_first   <= n_o_first;
        r_o_taken   <= n_o_taken;
        r_o_cfr     <= n_o_cfr;
        r_o_clsn    <= n_o_clsn;
        r_o_flsn    <= n_o_flsn;
        r_o_reached <= n_o_reached;
    end

    wfr_end_table #(
        .FRAMES (FRAMES)
    ) u_end_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata),
        .o_busy  (tbl_busy)
    );

    assign o_valid                  = r_o_valid;
    assign o_status                 = r_o_status;
    assign o_record_lsn             = r_o_rec_lsn;
    assign o_frame_index            = r_o_fidx;
    assign o_frame_offset           = r_o_foff;
    assign o_frame_closed           = r_o_closed;
    assign o_closed_frame_used      = r_o_used;
    assign o_closed_frame_first_lsn = r_o_first;
    assign o_frames_taken           = r_o_taken;
    assign o_cursor_frame           = r_o_cfr;
    assign o_cursor_lsn             = r_o_clsn;
    assign o_flushed_lsn            = r_o_flsn;
    assign o_reached                = r_o_reached;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfr_pkg::*;

    typedef struct packed {
        t_op         op;
        logic [15:0] body;
        logic [4:0]  limit;
        logic [63:0] target;
    } log_word_t;

    typedef struct packed {
        t_status     status;
        logic [63:0] record_lsn;
        logic [3:0]  frame_index;
        logic [11:0] frame_offset;
        logic        frame_closed;
        logic [11:0] closed_used;
        logic [63:0] closed_first_lsn;
        logic [4:0]  frames_taken;
        logic [3:0]  cursor_frame;
        logic [63:0] cursor_lsn;
        logic [63:0] flushed_lsn;
        logic        reached;
    } log_reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic [15:0] i_body_length = '0;
    logic [4:0]  i_take_limit = '0;
    logic [63:0] i_target_lsn = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_record_lsn;
    logic [3:0]  o_frame_index;
    logic [11:0] o_frame_offset;
    logic        o_frame_closed;
    logic [11:0] o_closed_frame_used;
    logic [63:0] o_closed_frame_first_lsn;
    logic [4:0]  o_frames_taken;
    logic [3:0]  o_cursor_frame;
    logic [63:0] o_cursor_lsn;
    logic [63:0] o_flushed_lsn;
    logic        o_reached;

    wal_frame_ring_lsn_allocator_top u_top (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_wdata              (i_cfg_wdata),
        .i_valid                  (i_valid),
        .o_ready                  (o_ready),
        .i_operation              (i_operation),
        .i_body_length            (i_body_length),
        .i_take_limit             (i_take_limit),
        .i_target_lsn             (i_target_lsn),
        .o_valid                  (o_valid),
        .i_ready                  (i_ready),
        .o_status                 (o_status),
        .o_record_lsn             (o_record_lsn),
        .o_frame_index            (o_frame_index),
        .o_frame_offset           (o_frame_offset),
        .o_frame_closed           (o_frame_closed),
        .o_closed_frame_used      (o_closed_frame_used),
        .o_closed_frame_first_lsn (o_closed_frame_first_lsn),
        .o_frames_taken           (o_frames_taken),
        .o_cursor_frame           (o_cursor_frame),
        .o_cursor_lsn             (o_cursor_lsn),
        .o_flushed_lsn            (o_flushed_lsn),
        .o_reached                (o_reached)
    );

    // log state as the block should hold it
    logic [16:0] budget = 17'(RING_BUDGET_RST);
    logic [63:0] log_head = '0;
    logic [63:0] flushed_to = '0;
    logic [3:0]  wr_frame = '0;
    int unsigned wr_fill = 0;
    logic [63:0] open_first = '0;
    logic [63:0] open_last = '0;
    logic [3:0]  rd_frame = '0;
    logic [63:0] frame_end [FRAMES_DEF];

    log_word_t   log_words [$];
    log_reply_t  expected_replies [$];
    int unsigned words_queued = 0;
    int unsigned words_accepted = 0;
    int unsigned replies_seen = 0;
    int unsigned mismatches = 0;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned recv_gap = 0;
    int unsigned recv_calm = 0;

    initial begin
        foreach (frame_end[k]) frame_end[k] = '0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic log_reply_t apply_log_op(input log_word_t w);
        log_reply_t  r;
        logic [63:0] total;
        logic [63:0] unflushed;
        logic [3:0]  avail;
        logic [4:0]  n;
        logic [3:0]  last;
        r = '0;
        case (w.op)
            OP_APPEND: begin
                total = 64'(RECORD_HEADER_BYTES) + 64'(w.body);
                // flushed ahead of written counts as nothing pending
                unflushed = (log_head > flushed_to) ? log_head - flushed_to : '0;
                if (total > 64'(MAX_RECORD_BYTES)) begin
                    r.status = STAT_TOO_LARGE;
                end else if (total > 64'(budget) || unflushed > 64'(budget) - total) begin
                    r.status = STAT_RING_FULL;
                end else begin
                    r.status = STAT_OK;
                    if (64'(wr_fill) + total > 64'(PAGE_DATA_BYTES)) begin
                        if (wr_fill > 0) begin
                            frame_end[wr_frame] = open_last;
                            r.frame_closed = 1'b1;
                            r.closed_used = 12'(wr_fill);
                            r.closed_first_lsn = open_first;
                        end
                        wr_frame = 4'((wr_frame + 1) % FRAMES_DEF);
                        wr_fill = 0;
                    end
                    r.record_lsn = log_head;
                    r.frame_index = wr_frame;
                    r.frame_offset = 12'(PAGE_HEADER_BYTES + wr_fill);
                    if (wr_fill == 0) open_first = log_head;
                    open_last = log_head;
                    wr_fill += 32'(total);
                    log_head += total;
                end
            end
            OP_TAKE: begin
                avail = 4'(wr_frame - rd_frame);
                n = ({1'b0, avail} < w.limit) ? {1'b0, avail} : w.limit;
                if (n > 0) begin
                    last = 4'(rd_frame + n[3:0] - 4'd1);
                    r.cursor_lsn = frame_end[last];
                    rd_frame = 4'(rd_frame + n[3:0]);
                end
                r.frames_taken = n;
                r.cursor_frame = rd_frame;
            end
            OP_MARK: begin
                if (w.target > flushed_to) flushed_to = w.target;
                r.reached = (flushed_to >= w.target);
            end
            default: begin
                r.reached = (flushed_to >= w.target);
            end
        endcase
        r.flushed_lsn = flushed_to;
        return r;
    endfunction

    // mostly short gaps, some long ones, and now and then a run with none
    function automatic int unsigned gap_len(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // marks track the (slightly stale) predicted head so the ring fills and drains
    function automatic log_word_t make_word();
        log_word_t   w;
        int unsigned r;
        logic [63:0] back;
        w.op = OP_APPEND;
        w.body = 16'($urandom);
        w.limit = 5'($urandom_range(0, 16));
        w.target = {$urandom, $urandom};
        back = 64'($urandom_range(0, 70000));
        r = $urandom_range(0, 99);
        if (r < 55) begin
            r = $urandom_range(0, 99);
            if (r < 65) w.body = 16'($urandom_range(0, 400));
            else if (r < 85) w.body = 16'($urandom_range(401, 4031));
            else if (r < 90) w.body = 16'(MAX_RECORD_BYTES - RECORD_HEADER_BYTES);
            else if (r < 97) w.body = 16'($urandom_range(4033, 65535));
        end else if (r < 70) begin
            w.op = OP_TAKE;
        end else if (r < 85) begin
            w.op = OP_MARK;
            r = $urandom_range(0, 99);
            if (r < 60) w.target = (log_head > back) ? log_head - back : '0;
            else if (r < 75) w.target = log_head;
            else if (r < 90) w.target = (flushed_to > back) ? flushed_to - back : '0;
            else w.target = log_head + back;
        end else begin
            w.op = OP_QUERY;
            r = $urandom_range(0, 99);
            if (r < 40) w.target = flushed_to + 64'($urandom_range(0, 2)) - 64'd1;
            else if (r < 70) w.target = flushed_to;
        end
        return w;
    endfunction

    task automatic push_word(input t_op op, input logic [15:0] body,
                             input logic [4:0] limit, input logic [63:0] target);
        log_word_t w;
        w.op = op;
        w.body = body;
        w.limit = limit;
        w.target = target;
        log_words.push_back(w);
        words_queued++;
    endtask

    task automatic run_random(input int unsigned count);
        log_word_t w;
        repeat (count) begin
            while (log_words.size() >= 4) @(posedge i_clk);
            w = make_word();
            push_word(w.op, w.body, w.limit, w.target);
        end
    endtask

    task automatic wait_drained();
        while (words_accepted != words_queued || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_budget(input logic [16:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        budget = value;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
            $display("  %s: expected %h, got %h", name, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin : drive_words
        log_word_t w;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                w.op = t_op'(i_operation);
                w.body = i_body_length;
                w.limit = i_take_limit;
                w.target = i_target_lsn;
                expected_replies.push_back(apply_log_op(w));
                words_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (log_words.size() > 0) begin
                    w = log_words.pop_front();
                    i_operation <= w.op;
                    i_body_length <= w.body;
                    i_take_limit <= w.limit;
                    i_target_lsn <= w.target;
                    i_valid <= 1'b1;
                    send_gap = gap_len(send_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        log_reply_t got;
        log_reply_t want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.status = t_status'(o_status);
                got.record_lsn = o_record_lsn;
                got.frame_index = o_frame_index;
                got.frame_offset = o_frame_offset;
                got.frame_closed = o_frame_closed;
                got.closed_used = o_closed_frame_used;
                got.closed_first_lsn = o_closed_frame_first_lsn;
                got.frames_taken = o_frames_taken;
                got.cursor_frame = o_cursor_frame;
                got.cursor_lsn = o_cursor_lsn;
                got.flushed_lsn = o_flushed_lsn;
                got.reached = o_reached;
                if (expected_replies.size() == 0) begin
                    if (mismatches < 10)
                        $display("reply %0d arrived with none expected", replies_seen);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("mismatch on reply %0d", replies_seen);
                            check_field("status", 64'(want.status), 64'(got.status));
                            check_field("record_lsn", want.record_lsn, got.record_lsn);
                            check_field("frame_index", 64'(want.frame_index),
                                        64'(got.frame_index));
                            check_field("frame_offset", 64'(want.frame_offset),
                                        64'(got.frame_offset));
                            check_field("frame_closed", 64'(want.frame_closed),
                                        64'(got.frame_closed));
                            check_field("closed_frame_used", 64'(want.closed_used),
                                        64'(got.closed_used));
                            check_field("closed_frame_first_lsn", want.closed_first_lsn,
                                        got.closed_first_lsn);
                            check_field("frames_taken", 64'(want.frames_taken),
                                        64'(got.frames_taken));
                            check_field("cursor_frame", 64'(want.cursor_frame),
                                        64'(got.cursor_frame));
                            check_field("cursor_lsn", want.cursor_lsn, got.cursor_lsn);
                            check_field("flushed_lsn", want.flushed_lsn, got.flushed_lsn);
                            check_field("reached", 64'(want.reached), 64'(got.reached));
                        end
                        mismatches++;
                    end
                end
                replies_seen++;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (o_valid && i_ready) recv_gap = gap_len(recv_calm);
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: boundaries of each operation at the reset budget
        push_word(OP_QUERY, 16'd0, 5'd0, 64'd0);
        push_word(OP_QUERY, 16'hFFFF, 5'd16, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(OP_APPEND, 16'd0, 5'd0, 64'd0);
        push_word(OP_APPEND, 16'(MAX_RECORD_BYTES - RECORD_HEADER_BYTES), 5'd0, 64'd0);
        push_word(OP_APPEND, 16'(MAX_RECORD_BYTES - RECORD_HEADER_BYTES + 1), 5'd0, 64'd0);
        push_word(OP_APPEND, 16'hFFFF, 5'd0, 64'd0);
        push_word(OP_TAKE, 16'd0, 5'd0, 64'd0);
        push_word(OP_TAKE, 16'd0, 5'd16, 64'd0);
        push_word(OP_TAKE, 16'd0, 5'd16, 64'd0);
        push_word(OP_MARK, 16'd0, 5'd0, 64'd100);
        push_word(OP_MARK, 16'd0, 5'd0, 64'd50);
        push_word(OP_QUERY, 16'd0, 5'd0, 64'd100);
        push_word(OP_QUERY, 16'd0, 5'd0, 64'd101);
        // flushed ahead of what has been written
        push_word(OP_MARK, 16'd0, 5'd0, 64'd10000);
        push_word(OP_APPEND, 16'd100, 5'd0, 64'd0);
        push_word(OP_APPEND, 16'd0, 5'd0, 64'd0);
        push_word(OP_MARK, 16'd0, 5'd0, 64'd0);
        push_word(OP_TAKE, 16'd0, 5'd5, 64'd0);
        push_word(OP_QUERY, 16'd0, 5'd0, 64'h8000_0000_0000_0000);
        repeat (3) push_word(OP_APPEND, 16'(MAX_RECORD_BYTES - RECORD_HEADER_BYTES),
                             5'd0, 64'd0);
        push_word(OP_TAKE, 16'd0, 5'd16, 64'd0);

        run_random(480);
        set_budget(17'd65536);
        run_random(400);
        set_budget(17'd0);
        run_random(60);
        set_budget(17'd300);
        run_random(150);
        set_budget(17'($urandom_range(4064, 65535)));
        run_random(400);
        set_budget(17'(RING_BUDGET_RST));
        run_random(340);

        // flush everything for good, then a few more words
        push_word(OP_MARK, 16'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(OP_APPEND, 16'd1000, 5'd0, 64'd0);
        push_word(OP_QUERY, 16'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(OP_TAKE, 16'd0, 5'd16, 64'd0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
